// ===== design/datetime_string_parser_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the date-time string parser
// Shared wrappers so every check uses the same clock, reset and report.
// ----------------------------------------------------------------------------
`ifndef DATETIME_STRING_PARSER_TOP_MACROS_SVH
`define DATETIME_STRING_PARSER_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define DTP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dtparse check failed");

// Next-cycle implication, disabled while in reset
`define DTP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dtparse check failed");

`endif

// ===== design/dtparse_pkg.sv =====
// ----------------------------------------------------------------------------
// dtparse_pkg
// Types and constants shared by the date-time string parser modules.
// ----------------------------------------------------------------------------
package dtparse_pkg;

  // Character codes
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // Field positions within the string
  localparam int unsigned DATE_DIGITS  = 8;
  localparam int unsigned TIME_END     = 14;
  localparam int unsigned FRACTION_END = 17;

  // Range limits and scaling
  localparam logic [6:0] HOUR_LIMIT   = 7'd24;
  localparam logic [6:0] MINSEC_LIMIT = 7'd60;
  localparam logic [9:0] MS_PER_SEC   = 10'd1000;

  // Widths
  localparam int unsigned POS_W  = 5;
  localparam int unsigned DATE_W = 32;
  localparam int unsigned SEC_W  = 17;
  localparam int unsigned MS_W   = 27;
  localparam int unsigned FRAC_W = 10;
  localparam int unsigned RES_W  = 1 + DATE_W + MS_W + POS_W;
  localparam int unsigned OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);

  // Classified character
  typedef struct packed {
    logic       first;
    logic       digit;
    logic [3:0] value;
  } item_t;

  // One result
  typedef struct packed {
    logic [POS_W-1:0]  consumed_count;
    logic [MS_W-1:0]   time_ms;
    logic [DATE_W-1:0] date_bcd;
    logic              parse_ok;
  } result_t;

endpackage

// ===== design/dtparse_queue.sv =====
// ----------------------------------------------------------------------------
// dtparse_queue
// Small flop-based FIFO of classified characters between front and back.
// ----------------------------------------------------------------------------
module dtparse_queue
  import dtparse_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output item_t pop_item,
  output logic  valid
);

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full     = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid    = (count != '0);
  assign pop_item = entries[rd_ptr];

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/dtparse_front.sv =====
// ----------------------------------------------------------------------------
// dtparse_front
// Input side: takes characters and classifies them as digit or not.
// ----------------------------------------------------------------------------
module dtparse_front
  import dtparse_pkg::*;
(
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // char_code[7:0]
  input  logic       s_tuser,   // first
  input  logic       queue_full,
  output logic       push,
  output item_t      push_item
);

  logic       is_digit;
  logic [7:0] offset;

  // Accept whenever the queue has room
  assign s_tready = !queue_full;
  assign push     = s_tvalid && s_tready;

  // Classify the character
  always_comb begin
    is_digit = (s_tdata >= CHAR_ZERO) && (s_tdata <= CHAR_NINE);
    offset   = s_tdata - CHAR_ZERO;
    push_item.first = s_tuser;
    push_item.digit = is_digit;
    push_item.value = is_digit ? offset[3:0] : 4'd0;
  end

endmodule

// ===== design/dtparse_back.sv =====
// ----------------------------------------------------------------------------
// dtparse_back
// Parser state and result register; consumes one classified character per
// cycle while the output is not stalled and produces at most one result per string.
// ----------------------------------------------------------------------------
module dtparse_back
  import dtparse_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  item_t                  q_item,
  output logic                   pop,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata  // parse_ok, date_bcd, time_ms, consumed_count, zero pad
);

  // Parse state
  logic [POS_W-1:0]  position, position_next;
  logic [DATE_W-1:0] date_accum, date_accum_next;
  logic [3:0]        pair_value, pair_value_next;
  logic [SEC_W-1:0]  sec_accum, sec_accum_next;
  logic [FRAC_W-1:0] frac_accum, frac_accum_next;
  logic              finished, finished_next;
  logic              range_bad, range_bad_next;

  result_t           result;

  // Effective state after a possible restart
  logic [POS_W-1:0]  pos_e;
  logic [DATE_W-1:0] date_e;
  logic [3:0]        pair_e;
  logic [SEC_W-1:0]  sec_e;
  logic [FRAC_W-1:0] frac_e;
  logic              fin_e;
  logic              bad_e;

  logic [6:0]        pair_full;
  logic [6:0]        limit;
  logic [22:0]       sec_scaled;
  logic [FRAC_W-1:0] frac_add;
  logic [FRAC_W-1:0] frac_sum;
  logic [FRAC_W-1:0] frac_out;
  logic [MS_W-1:0]   ms_total;
  logic              emit_ok;
  logic              emit_fail;
  logic [POS_W-1:0]  emit_pos;

  assign pop = q_valid && (!m_tvalid || m_tready);

  // Next-state logic for one character
  always_comb begin
    fin_e  = q_item.first ? 1'b0 : finished;
    pos_e  = q_item.first ? '0 : position;
    date_e = q_item.first ? '0 : date_accum;
    pair_e = q_item.first ? '0 : pair_value;
    sec_e  = q_item.first ? '0 : sec_accum;
    frac_e = q_item.first ? '0 : frac_accum;
    bad_e  = q_item.first ? 1'b0 : range_bad;

    position_next   = pos_e;
    date_accum_next = date_e;
    pair_value_next = pair_e;
    sec_accum_next  = sec_e;
    frac_accum_next = frac_e;
    finished_next   = fin_e;
    range_bad_next  = bad_e;

    pair_full  = 7'(pair_e) * 7'd10 + 7'(q_item.value);
    limit      = (pos_e == POS_W'(DATE_DIGITS + 1)) ? HOUR_LIMIT : MINSEC_LIMIT;
    sec_scaled = 23'(sec_e) * 23'd60 + 23'(pair_full);

    // Fraction digit weight by its place
    case (pos_e)
      POS_W'(TIME_END):     frac_add = 10'(q_item.value) * 10'd100;
      POS_W'(TIME_END + 1): frac_add = 10'(q_item.value) * 10'd10;
      default:              frac_add = 10'(q_item.value);
    endcase
    frac_sum = frac_e + frac_add;

    emit_ok   = 1'b0;
    emit_fail = 1'b0;
    emit_pos  = pos_e;
    frac_out  = frac_e;

    if (!fin_e) begin
      if (pos_e < POS_W'(TIME_END)) begin
        if (!q_item.digit) begin
          emit_fail     = 1'b1;
          finished_next = 1'b1;
        end else begin
          position_next = pos_e + 1'b1;
          if (pos_e < POS_W'(DATE_DIGITS)) begin
            date_accum_next = {date_e[DATE_W-5:0], q_item.value};
          end else if (!pos_e[0]) begin
            // First digit of a time pair (positions 8, 10, 12 are even)
            pair_value_next = q_item.value;
          end else begin
            if (pair_full >= limit) begin
              range_bad_next = 1'b1;
            end
            sec_accum_next = sec_scaled[SEC_W-1:0];
            if (pos_e == POS_W'(TIME_END - 1) && (bad_e || pair_full >= limit)) begin
              emit_fail     = 1'b1;
              finished_next = 1'b1;
            end
          end
        end
      end else if (!q_item.digit) begin
        // Terminator is not consumed
        emit_ok       = 1'b1;
        finished_next = 1'b1;
      end else begin
        frac_accum_next = frac_sum;
        position_next   = pos_e + 1'b1;
        if (pos_e == POS_W'(FRACTION_END - 1)) begin
          emit_ok       = 1'b1;
          emit_pos      = POS_W'(FRACTION_END);
          frac_out      = frac_sum;
          finished_next = 1'b1;
        end
      end
    end

    ms_total = MS_W'(sec_e) * MS_W'(MS_PER_SEC) + MS_W'(frac_out);

    result = '0;
    if (emit_ok) begin
      result.parse_ok       = 1'b1;
      result.date_bcd       = date_e;
      result.time_ms        = ms_total;
      result.consumed_count = emit_pos;
    end
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      position   <= '0;
      date_accum <= '0;
      pair_value <= '0;
      sec_accum  <= '0;
      frac_accum <= '0;
      finished   <= 1'b1;
      range_bad  <= 1'b0;
    end else if (pop) begin
      position   <= position_next;
      date_accum <= date_accum_next;
      pair_value <= pair_value_next;
      sec_accum  <= sec_accum_next;
      frac_accum <= frac_accum_next;
      finished   <= finished_next;
      range_bad  <= range_bad_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop && (emit_ok || emit_fail)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (emit_ok || emit_fail)) begin
      m_tdata <= OUT_TDATA_W'(result);
    end
  end

endmodule

// ===== design/datetime_string_parser_top.sv =====
// ----------------------------------------------------------------------------
// datetime_string_parser_top
// Parses "YYYYMMDDhhmmss[fff]" character streams into BCD date and
// milliseconds since midnight.
//
//  Port group | Direction | Payload
//  -----------+-----------+-------------------------------------------------
//  s_*        | in        | tdata: char_code[7:0]; tuser: first
//  m_*        | out       | tdata: parse_ok, date_bcd, time_ms, consumed_count
//
// One character per cycle sustained unless the output stalls; the character
// that ends the string passes the queue write, then the parser step into
// the output register. The parser step with its constant multiply-adds sets
// the rate. After reset no string is active until a first character.
// A stalled output holds the parser; the four-entry queue absorbs input.
// ----------------------------------------------------------------------------
module datetime_string_parser_top
  import dtparse_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,   // char_code[7:0]
  input  logic                   s_tuser,   // first
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // parse_ok[0], date_bcd[32:1],
                                            // time_ms[59:33], consumed_count[64:60]
);

  logic  push;
  item_t push_item;
  logic  queue_full;
  logic  pop;
  item_t pop_item;
  logic  q_valid;

  // Front: input transactions and character classification
  dtparse_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  // Queue between front and back
  dtparse_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .valid     (q_valid)
  );

  // Back: parser and result register
  dtparse_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (pop_item),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== design/dtparse_checker.sv =====
// ----------------------------------------------------------------------------
// dtparse_checker
// Port-level checks on the result stream of the date-time string parser.
// ----------------------------------------------------------------------------
`include "datetime_string_parser_top_macros.svh"

module dtparse_checker
  import dtparse_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  logic [POS_W-1:0] res_count;
  logic [MS_W-1:0]  res_time;

  assign res_count = m_tdata[64:60];
  assign res_time  = m_tdata[59:33];

  // A failure transaction carries all-zero fields
  `DTP_ASSERT_NOW(a_fail_zero, m_tvalid && !m_tdata[0], m_tdata[OUT_TDATA_W-1:1] == '0)

  // A success reports between fourteen and seventeen characters
  `DTP_ASSERT_NOW(a_ok_count, m_tvalid && m_tdata[0], res_count >= 5'd14 && res_count <= 5'd17)

  // A success time lies within one day
  `DTP_ASSERT_NOW(a_ok_time, m_tvalid && m_tdata[0], res_time < 27'd86400000)

  // A stalled result holds
  `DTP_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind datetime_string_parser_top dtparse_checker u_dtparse_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
